FILE: hdl/mos_pkg.sv
package mos_pkg;

    localparam int CAPACITY = 512;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int FILL_W   = $clog2(CAPACITY + 1);

    localparam int SCORE_W  = 16;
    localparam int VALUE_W  = 15;
    localparam int MEDIAN_W = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 10;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [VALUE_W-1:0] MAX_SCORE_RESET = 15'd5120;

    localparam logic [STATUS_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ERR_FULL  = 2'd2;

    localparam logic REG_MAX_SCORE = 1'b0;

endpackage

FILE: hdl/mos_if.sv
interface mos_in_if
    import mos_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic                      last;

    modport source (output valid, output score, output last, input ready);
    modport sink   (input valid, input score, input last, output ready);
endinterface

interface mos_out_if
    import mos_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [MEDIAN_W-1:0] median_twice;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output median_twice, output status, output count, input ready);
    modport sink   (input valid, input median_twice, input status, input count, output ready);
endinterface

FILE: hdl/mos_ram.sv
module mos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hdl/median_of_scores.sv
// Median of a set of scores. Each input transfer carries one score (signed, 8 fraction
// bits) and a last flag. Scores are range checked against 0 and max_score (APB register 0)
// and kept sorted in a single-port RAM by insertion as they arrive: each stored score
// above the new one is shifted up one slot, and the input is held not ready until the
// insert is done; a score that is dropped or raises an error is not inserted. After the
// last score the two middle entries are read back (not on an error or an empty set) and
// the result, twice the median with status and count, is posted to an output register;
// the next set may start loading while that result waits. On an error the rest of the
// set is dropped and the result carries a zero median.
module median_of_scores
    import mos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    mos_in_if.sink             in_ch,
    mos_out_if.source          out_ch
);

    typedef enum logic [2:0] {
        IDLE,
        INS,
        CMP,
        MED,
        RD_HI,
        ACC,
        POST
    } state_t;

    state_t              state_reg, state_next;
    logic [VALUE_W-1:0]  max_reg, max_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                last_reg, last_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   j_reg, j_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [MEDIAN_W-1:0] sum_reg, sum_next;
    logic                ov_reg, ov_next;
    logic [MEDIAN_W-1:0] med_reg, med_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic [VALUE_W-1:0]  ram_rdata;
    logic [FILL_W-1:0]   half;
    logic [ADDR_W-1:0]   lo_idx;
    logic [ADDR_W-1:0]   hi_idx;
    logic                cfg_wr;

    mos_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[PADDR_W-1] == REG_MAX_SCORE) ? PDATA_W'(max_reg) : '0;

    assign in_ch.ready         = (state_reg == IDLE);
    assign out_ch.valid        = ov_reg;
    assign out_ch.median_twice = med_reg;
    assign out_ch.status       = stat_reg;
    assign out_ch.count        = cnt_reg;

    // odd count: both indexes at n/2; even: n/2-1 and n/2
    assign half   = fill_reg >> 1;
    assign hi_idx = half[ADDR_W-1:0];
    assign lo_idx = fill_reg[0] ? half[ADDR_W-1:0] : ADDR_W'(half - FILL_W'(1));

    always_comb
    begin
        state_next = state_reg;
        max_next   = max_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        fill_next  = fill_reg;
        j_next     = j_reg;
        err_next   = err_reg;
        sum_next   = sum_reg;
        ov_next    = ov_reg;
        med_next   = med_reg;
        stat_next  = stat_reg;
        cnt_next   = cnt_reg;
        ram_we     = 1'b0;
        ram_addr   = j_reg[ADDR_W-1:0];
        ram_wdata  = val_reg;

        if (cfg_wr && paddr[PADDR_W-1] == REG_MAX_SCORE)
        begin
            max_next = pwdata[VALUE_W-1:0];
        end

        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            IDLE:
            begin
                if (in_ch.valid)
                begin
                    val_next   = in_ch.score[VALUE_W-1:0];
                    last_next  = in_ch.last;
                    state_next = in_ch.last ? MED : IDLE;
                    if (err_reg == ERR_NONE)
                    begin
                        if (fill_reg >= FILL_W'(CAPACITY))
                        begin
                            err_next = ERR_FULL;
                        end
                        else if (in_ch.score[SCORE_W-1] ||
                                 in_ch.score[VALUE_W-1:0] > max_reg)
                        begin
                            err_next = ERR_RANGE;
                        end
                        else
                        begin
                            j_next     = fill_reg;
                            state_next = INS;
                        end
                    end
                end
            end
            INS:
            begin
                if (j_reg == '0)
                begin
                    ram_we     = 1'b1;
                    fill_next  = fill_reg + FILL_W'(1);
                    state_next = last_reg ? MED : IDLE;
                end
                else
                begin
                    ram_addr   = ADDR_W'(j_reg - FILL_W'(1));
                    state_next = CMP;
                end
            end
            CMP:
            begin
                ram_we = 1'b1;
                if (ram_rdata > val_reg)
                begin
                    // shift the larger entry up one slot
                    ram_wdata  = ram_rdata;
                    j_next     = j_reg - FILL_W'(1);
                    state_next = INS;
                end
                else
                begin
                    fill_next  = fill_reg + FILL_W'(1);
                    state_next = last_reg ? MED : IDLE;
                end
            end
            MED:
            begin
                if (err_reg != ERR_NONE || fill_reg == '0)
                begin
                    sum_next   = '0;
                    state_next = POST;
                end
                else
                begin
                    ram_addr   = lo_idx;
                    state_next = RD_HI;
                end
            end
            RD_HI:
            begin
                ram_addr   = hi_idx;
                sum_next   = MEDIAN_W'(ram_rdata);
                state_next = ACC;
            end
            ACC:
            begin
                sum_next   = sum_reg + MEDIAN_W'(ram_rdata);
                state_next = POST;
            end
            POST:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    med_next   = sum_reg;
                    stat_next  = err_reg;
                    cnt_next   = COUNT_W'(fill_reg);
                    fill_next  = '0;
                    err_next   = ERR_NONE;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            max_reg   <= MAX_SCORE_RESET;
            val_reg   <= '0;
            last_reg  <= 1'b0;
            fill_reg  <= '0;
            j_reg     <= '0;
            err_reg   <= ERR_NONE;
            sum_reg   <= '0;
            ov_reg    <= 1'b0;
            med_reg   <= '0;
            stat_reg  <= ERR_NONE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            max_reg   <= max_next;
            val_reg   <= val_next;
            last_reg  <= last_next;
            fill_reg  <= fill_next;
            j_reg     <= j_next;
            err_reg   <= err_next;
            sum_reg   <= sum_next;
            ov_reg    <= ov_next;
            med_reg   <= med_next;
            stat_reg  <= stat_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hdl/mos_checker.sv
module mos_checker
    import mos_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [MEDIAN_W-1:0] out_median_twice,
    input logic [STATUS_W-1:0] out_status,
    input logic [COUNT_W-1:0]  out_count
);

    // a result holds until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_median_twice)
            && $stable(out_status) && $stable(out_count))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ERR_NONE |-> out_median_twice == '0)
        else $error("nonzero median on error");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == ERR_FULL |-> out_count == COUNT_W'(CAPACITY))
        else $error("overflow with store not full");

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == ERR_NONE |-> out_count != '0)
        else $error("good result with empty set");

endmodule

bind median_of_scores mos_checker u_mos_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_median_twice (out_ch.median_twice),
    .out_status       (out_ch.status),
    .out_count        (out_ch.count)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic [mos_pkg::MEDIAN_W-1:0] median_twice;
    logic [mos_pkg::STATUS_W-1:0] status;
    logic [mos_pkg::COUNT_W-1:0]  count;
} median_result_t;

// Tracks the scores of the open set and the results owed by the block.
class median_tracker;
    logic [mos_pkg::VALUE_W-1:0]  max_score;
    logic [mos_pkg::VALUE_W-1:0]  held_scores[$];
    logic [mos_pkg::STATUS_W-1:0] set_error;
    median_result_t               owed_results[$];
    int                           mismatches;

    function new();
        max_score  = mos_pkg::MAX_SCORE_RESET;
        set_error  = mos_pkg::ERR_NONE;
        mismatches = 0;
    endfunction

    function void take_score(logic signed [mos_pkg::SCORE_W-1:0] score, logic last);
        median_result_t res;
        int             n;
        if (set_error == mos_pkg::ERR_NONE)
        begin
            // full check wins over the range check
            if (held_scores.size() >= mos_pkg::CAPACITY)
                set_error = mos_pkg::ERR_FULL;
            else if (score[mos_pkg::SCORE_W-1] || score[mos_pkg::VALUE_W-1:0] > max_score)
                set_error = mos_pkg::ERR_RANGE;
            else
                held_scores.push_back(score[mos_pkg::VALUE_W-1:0]);
        end
        if (last)
        begin
            n = held_scores.size();
            res.median_twice = '0;
            if (set_error == mos_pkg::ERR_NONE && n > 0)
            begin
                held_scores.sort();
                if (n % 2 == 1)
                    res.median_twice = {held_scores[(n - 1) / 2], 1'b0};
                else
                    res.median_twice = mos_pkg::MEDIAN_W'(held_scores[n / 2 - 1])
                                     + mos_pkg::MEDIAN_W'(held_scores[n / 2]);
            end
            res.status = set_error;
            res.count  = mos_pkg::COUNT_W'(n);
            owed_results.push_back(res);
            held_scores.delete();
            set_error = mos_pkg::ERR_NONE;
        end
    endfunction

    function void check_result(median_result_t got);
        median_result_t want;
        if (owed_results.size() == 0)
        begin
            $error("result transfer with no result owed: median_twice %0d status %0d count %0d",
                   got.median_twice, got.status, got.count);
            mismatches++;
            return;
        end
        want = owed_results.pop_front();
        if (got.median_twice !== want.median_twice)
        begin
            $error("median_twice: expected %0d, actual %0d", want.median_twice,
                   got.median_twice);
            mismatches++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
        end
        if (got.count !== want.count)
        begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
            mismatches++;
        end
    endfunction
endclass

module tb;
    import mos_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PHASE_ITEMS   = 8;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mos_in_if  score_ch();
    mos_out_if median_ch();

    median_tracker tracker;
    bit            steady;
    int            cycle_count = 0;

    median_of_scores u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (score_ch),
        .out_ch  (median_ch)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("median_of_scores regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && median_ch.valid && median_ch.ready)
            tracker.check_result('{median_twice: median_ch.median_twice,
                                   status: median_ch.status, count: median_ch.count});
    end

    function automatic int pick_gap(bit no_gaps);
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver back-pressure, with occasional long open stretches
    initial
    begin
        int stall;
        int open;
        median_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap(1'b0);
            if (stall > 0)
            begin
                median_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            median_ch.ready <= 1'b1;
            open = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 6);
            repeat (open) @(posedge clk);
        end
    end

    // valid stays high across back-to-back transfers; only dropped for a gap
    task automatic send_score(input logic signed [SCORE_W-1:0] score, input logic last);
        int gap;
        gap = pick_gap(steady);
        if (gap > 0)
        begin
            score_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        score_ch.valid <= 1'b1;
        score_ch.score <= score;
        score_ch.last  <= last;
        do
            @(posedge clk);
        while (!score_ch.ready);
        tracker.take_score(score, last);
    endtask

    task automatic send_set(input int scores[$]);
        foreach (scores[i])
            send_score(SCORE_W'(scores[i]), i == scores.size() - 1);
    endtask

    task automatic drain();
        score_ch.valid <= 1'b0;
        while (tracker.owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_score(input logic [VALUE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_MAX_SCORE));
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.max_score = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [SCORE_W-1:0] good_score();
        return SCORE_W'($urandom_range(0, int'(tracker.max_score)));
    endfunction

    function automatic logic [SCORE_W-1:0] bad_score();
        if (tracker.max_score == 15'h7fff || $urandom_range(0, 1) == 0)
            return SCORE_W'(-$urandom_range(1, 32768));
        return SCORE_W'($urandom_range(int'(tracker.max_score) + 1, 32767));
    endfunction

    // mostly clean sets with random content; some broken or noisy ones
    task automatic random_set(inout int sent);
        int                   n;
        int                   kind;
        int                   r;
        logic [SCORE_W-1:0]   score;
        r = $urandom_range(0, 99);
        if (r < 70)
            n = $urandom_range(1, 8);
        else if (r < 95)
            n = $urandom_range(9, 24);
        else
            n = $urandom_range(25, 60);
        kind = $urandom_range(0, 99);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (kind < 70)
                score = (r < 2) ? bad_score() : good_score();
            else if (kind < 82)
                // few distinct values, so ties show up in the sort
                score = SCORE_W'($urandom_range(0, (tracker.max_score < 3)
                                                   ? int'(tracker.max_score) : 3));
            else if (r < 20)
                score = bad_score();
            else if (r < 40)
                score = SCORE_W'($urandom());
            else
                score = good_score();
            send_score(score, i == n - 1);
            sent++;
        end
    endtask

    initial
    begin
        int sent;
        tracker = new();
        steady  = 1'b0;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        score_ch.valid <= 1'b0;
        score_ch.score <= '0;
        score_ch.last  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit of 20.0
        send_set('{0});
        send_set('{5120});
        send_set('{300, 100, 200});
        send_set('{5120, 0, 7, 3});
        send_set('{5121});
        send_set('{-1, 10, 20});
        send_set('{10, -32768, 5});
        send_set('{10, 20, 32767, 4});
        drain();

        write_max_score(15'h7fff);
        send_set('{32767});
        send_set('{32767, 32767});
        send_set('{0, 32767});
        // full store, ascending so each insert is cheap
        steady = 1'b1;
        for (int i = 0; i < CAPACITY; i++)
            send_score(SCORE_W'(i * 64), 1'b0);
        steady = 1'b0;
        // one past capacity: full must win over out of range
        send_score(-16'sd5, 1'b0);
        send_score(16'sd100, 1'b1);
        drain();

        write_max_score('0);
        send_set('{0});
        send_set('{1});
        send_set('{0, 0, 0});
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       write_max_score(15'h7fff);
                2:       write_max_score(VALUE_W'($urandom_range(0, 255)));
                default: write_max_score(VALUE_W'($urandom_range(0, 32767)));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_ITEMS)
                random_set(sent);
            drain();
        end

        if (tracker.owed_results.size() != 0)
        begin
            $error("%0d results never arrived", tracker.owed_results.size());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0)
            $display("median_of_scores regression: pass");
        else
            $display("median_of_scores regression: fail");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/mos_pkg.sv
hdl/mos_if.sv
hdl/mos_ram.sv
hdl/median_of_scores.sv
hdl/mos_checker.sv
bench/tb.sv
